>>> rtl/core/nps_pkg.sv
// nps_pkg: shared types and constants for the nearest point search block
// no dependencies; used by nearest_point_search, nps_ctrl, nps_dist and nps_best

package nps_pkg;

    localparam int MAX_POINTS_DEF = 1024;
    localparam int COORD_BITS_DEF = 24;

    localparam int INDEX_BITS     = 10;
    localparam int DIST_BITS      = 63;
    localparam int COUNT_OUT_BITS = 11;
    localparam int WEIGHT_BITS    = 16;
    localparam int CFG_INDEX_BITS = 8;
    localparam int CMD_BITS       = 2;
    localparam int FLAG_BITS      = 2;

    localparam logic [DIST_BITS-1:0]   DIST_MAX      = {DIST_BITS{1'b1}};
    localparam logic [WEIGHT_BITS-1:0] WEIGHT_RESET  = 16'd256;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_X_WEIGHT = 8'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_Y_WEIGHT = 8'd1;

    typedef enum logic [CMD_BITS-1:0] {
        CMD_CLEAR      = 2'd0,
        CMD_ADD        = 2'd1,
        CMD_NEAREST_X  = 2'd2,
        CMD_NEAREST_2D = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_SCAN  = 2'd1,
        ST_DRAIN = 2'd2,
        ST_DONE  = 2'd3
    } state_t;

    typedef struct packed {
        logic s_ready;
        logic rd_en;
        logic load_out;
    } scan_ctrl_t;

endpackage

>>> rtl/core/nearest_point_search.sv
// nearest_point_search: top level, point store with linear nearest point scan
// depends on nps_pkg, nps_ram, nps_ctrl, nps_dist, nps_best

// Takes one command transaction at a time and returns one result transaction
// for each. Clear and add go from idle straight to the done state. A
// nearest-by-x or weighted 2d query reads the point memory through its single
// read port, one stored point per cycle, and pushes each point down a
// five-cell distance chain; the query is done once the chain has drained. A
// finished result sits in the output register, and the next command is
// taken while it waits there. Weight writes on the cfg channel are always
// ready and take effect at once.

module nearest_point_search #(
    parameter int MAX_POINTS = nps_pkg::MAX_POINTS_DEF,
    parameter int COORD_BITS = nps_pkg::COORD_BITS_DEF
) (
    input  logic aclk,
    input  logic aresetn,

    input  logic                                       s_axis_tvalid,
    output logic                                       s_axis_tready,
    // x_coord, y_coord
    input  logic [((2*COORD_BITS+7)/8)*8-1:0]          s_axis_tdata,
    // command
    input  logic [nps_pkg::CMD_BITS-1:0]               s_axis_tuser,

    output logic                                       m_axis_tvalid,
    input  logic                                       m_axis_tready,
    // nearest_index, distance, sel_x, sel_y, stored_count, x_min, x_max, y_min, y_max
    output logic [((nps_pkg::INDEX_BITS + nps_pkg::DIST_BITS + nps_pkg::COUNT_OUT_BITS
                    + 6*COORD_BITS + 7)/8)*8-1:0]      m_axis_tdata,
    // found, dropped
    output logic [nps_pkg::FLAG_BITS-1:0]              m_axis_tuser,

    input  logic                                       cfg_valid,
    output logic                                       cfg_ready,
    input  logic [nps_pkg::CFG_INDEX_BITS-1:0]         cfg_index,
    input  logic [nps_pkg::WEIGHT_BITS-1:0]            cfg_data
);

    localparam int IDX_BITS   = $clog2(MAX_POINTS);
    localparam int COUNT_BITS = $clog2(MAX_POINTS + 1);
    localparam int M_BITS     = ((nps_pkg::INDEX_BITS + nps_pkg::DIST_BITS
                                + nps_pkg::COUNT_OUT_BITS + 6*COORD_BITS + 7)/8)*8;
    localparam logic signed [COORD_BITS-1:0] C_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam logic signed [COORD_BITS-1:0] C_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

    nps_pkg::scan_ctrl_t ctrl;
    nps_pkg::cmd_t       cmd_in, cmd_reg;

    logic                          s_fire, out_free, full, add_ok;
    logic signed [COORD_BITS-1:0]  in_x, in_y;
    logic [COORD_BITS-1:0]         qx_reg, qy_reg;
    logic [COUNT_BITS-1:0]         count_reg;
    logic signed [COORD_BITS-1:0]  x_min_reg, x_max_reg, y_min_reg, y_max_reg;
    logic [nps_pkg::WEIGHT_BITS-1:0] x_weight_reg, y_weight_reg;
    logic                          dropped_reg;

    logic [IDX_BITS-1:0]           rd_addr, ram_idx_reg;
    logic                          ram_valid_reg;
    logic [2*COORD_BITS-1:0]       ram_rdata;

    logic                          d_valid, d_busy, busy;
    logic [IDX_BITS-1:0]           d_idx, b_idx;
    logic [COORD_BITS-1:0]         d_x, d_y, b_x, b_y;
    logic [nps_pkg::DIST_BITS-1:0] d_dist, b_dist, out_dist;
    logic                          b_found, is_query;

    logic                          m_valid_reg;
    logic [M_BITS-1:0]             m_data_reg;
    logic [nps_pkg::FLAG_BITS-1:0] m_user_reg;

    assign cmd_in   = nps_pkg::cmd_t'(s_axis_tuser);
    assign in_x     = s_axis_tdata[COORD_BITS-1:0];
    assign in_y     = s_axis_tdata[2*COORD_BITS-1:COORD_BITS];
    assign s_fire   = s_axis_tvalid && ctrl.s_ready;
    assign out_free = !m_valid_reg || m_axis_tready;
    assign full     = (count_reg >= COUNT_BITS'(MAX_POINTS));
    assign add_ok   = s_fire && (cmd_in == nps_pkg::CMD_ADD) && !full;
    assign busy     = ram_valid_reg || d_busy;
    assign is_query = (cmd_reg == nps_pkg::CMD_NEAREST_X)
                   || (cmd_reg == nps_pkg::CMD_NEAREST_2D);

    // weight registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_weight_reg <= nps_pkg::WEIGHT_RESET;
            y_weight_reg <= nps_pkg::WEIGHT_RESET;
        end else if (cfg_valid) begin
            if (cfg_index == nps_pkg::CFG_X_WEIGHT) begin
                x_weight_reg <= cfg_data;
            end
            if (cfg_index == nps_pkg::CFG_Y_WEIGHT) begin
                y_weight_reg <= cfg_data;
            end
        end
    end

    // point count, running extremes, command capture
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            x_min_reg   <= C_MAX;
            y_min_reg   <= C_MAX;
            x_max_reg   <= C_MIN;
            y_max_reg   <= C_MIN;
            dropped_reg <= 1'b0;
            cmd_reg     <= nps_pkg::CMD_CLEAR;
        end else if (s_fire) begin
            cmd_reg     <= cmd_in;
            dropped_reg <= (cmd_in == nps_pkg::CMD_ADD) && full;
            if (cmd_in == nps_pkg::CMD_CLEAR) begin
                count_reg <= '0;
                x_min_reg <= C_MAX;
                y_min_reg <= C_MAX;
                x_max_reg <= C_MIN;
                y_max_reg <= C_MIN;
            end else if (add_ok) begin
                count_reg <= count_reg + 1'b1;
                if (in_x < x_min_reg) x_min_reg <= in_x;
                if (in_x > x_max_reg) x_max_reg <= in_x;
                if (in_y < y_min_reg) y_min_reg <= in_y;
                if (in_y > y_max_reg) y_max_reg <= in_y;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            qx_reg <= in_x;
            qy_reg <= in_y;
        end
    end

    nps_ram #(
        .WIDTH (2*COORD_BITS),
        .DEPTH (MAX_POINTS)
    ) u_store (
        .aclk  (aclk),
        .we    (add_ok),
        .waddr (count_reg[IDX_BITS-1:0]),
        .wdata ({in_y, in_x}),
        .re    (ctrl.rd_en),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ram_valid_reg <= 1'b0;
        end else begin
            ram_valid_reg <= ctrl.rd_en;
        end
    end

    always_ff @(posedge aclk) begin
        ram_idx_reg <= rd_addr;
    end

    nps_ctrl #(
        .MAX_POINTS (MAX_POINTS)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_fire   (s_fire),
        .cmd      (cmd_in),
        .count    (count_reg),
        .busy     (busy),
        .out_free (out_free),
        .ctrl     (ctrl),
        .rd_addr  (rd_addr)
    );

    nps_dist #(
        .COORD_BITS (COORD_BITS),
        .IDX_BITS   (IDX_BITS)
    ) u_dist (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .mode_2d   (cmd_reg == nps_pkg::CMD_NEAREST_2D),
        .qx        (qx_reg),
        .qy        (qy_reg),
        .x_weight  (x_weight_reg),
        .y_weight  (y_weight_reg),
        .in_valid  (ram_valid_reg),
        .in_idx    (ram_idx_reg),
        .in_x      (ram_rdata[COORD_BITS-1:0]),
        .in_y      (ram_rdata[2*COORD_BITS-1:COORD_BITS]),
        .out_valid (d_valid),
        .out_idx   (d_idx),
        .out_x     (d_x),
        .out_y     (d_y),
        .out_dist  (d_dist),
        .busy      (d_busy)
    );

    nps_best #(
        .COORD_BITS (COORD_BITS),
        .IDX_BITS   (IDX_BITS)
    ) u_best (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .clear     (s_fire),
        .in_valid  (d_valid),
        .in_idx    (d_idx),
        .in_x      (d_x),
        .in_y      (d_y),
        .in_dist   (d_dist),
        .found     (b_found),
        .best_idx  (b_idx),
        .best_x    (b_x),
        .best_y    (b_y),
        .best_dist (b_dist)
    );

    // clear and add report zero distance
    assign out_dist = is_query ? b_dist : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (ctrl.load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load_out) begin
            m_user_reg <= {dropped_reg, b_found};
            m_data_reg <= M_BITS'({y_max_reg, y_min_reg, x_max_reg, x_min_reg,
                                   nps_pkg::COUNT_OUT_BITS'(count_reg),
                                   b_y, b_x, out_dist,
                                   nps_pkg::INDEX_BITS'(b_idx)});
        end
    end

    assign s_axis_tready = ctrl.s_ready;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;
    assign cfg_ready     = 1'b1;

endmodule

>>> rtl/core/nps_ram.sv
// nps_ram: generic simple dual port ram, one write and one registered read port
// no dependencies

module nps_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/core/nps_dist.sv
// nps_dist: chain of distance cells, one stored point enters per cycle
// depends on nps_pkg

module nps_dist #(
    parameter int COORD_BITS = nps_pkg::COORD_BITS_DEF,
    parameter int IDX_BITS   = 10
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            mode_2d,
    input  logic [COORD_BITS-1:0]           qx,
    input  logic [COORD_BITS-1:0]           qy,
    input  logic [nps_pkg::WEIGHT_BITS-1:0] x_weight,
    input  logic [nps_pkg::WEIGHT_BITS-1:0] y_weight,
    input  logic                            in_valid,
    input  logic [IDX_BITS-1:0]             in_idx,
    input  logic [COORD_BITS-1:0]           in_x,
    input  logic [COORD_BITS-1:0]           in_y,
    output logic                            out_valid,
    output logic [IDX_BITS-1:0]             out_idx,
    output logic [COORD_BITS-1:0]           out_x,
    output logic [COORD_BITS-1:0]           out_y,
    output logic [nps_pkg::DIST_BITS-1:0]   out_dist,
    output logic                            busy
);

    localparam int STAGES = 5;
    localparam int DW     = COORD_BITS + 1;
    localparam int SQ     = 2 * COORD_BITS;
    localparam int PW     = 32 + nps_pkg::WEIGHT_BITS;

    // floor(sq * w / 256) from the two partial products, saturated
    function automatic logic [nps_pkg::DIST_BITS-1:0] wterm(
        input logic [PW-1:0] hiw,
        input logic [PW-1:0] low
    );
        logic [63:0] r;
        r = {1'b0, hiw[38:0], 24'd0} + {24'd0, low[PW-1:8]};
        if (hiw[PW-1:39] != '0 || r[63]) begin
            return nps_pkg::DIST_MAX;
        end
        return r[62:0];
    endfunction

    logic [STAGES-1:0]     v_reg;
    logic [IDX_BITS-1:0]   idx_reg [STAGES];
    logic [COORD_BITS-1:0] x_reg   [STAGES];
    logic [COORD_BITS-1:0] y_reg   [STAGES];
    logic [COORD_BITS-1:0] dx_reg  [STAGES-1];

    logic signed [DW-1:0]  dxs, dys;
    logic [COORD_BITS-1:0] dx_next, dy_next, dy_reg;
    logic [SQ-1:0]         sqx_reg, sqy_reg;
    logic [63:0]           sqx64, sqy64;
    logic [PW-1:0]         hx_reg, lx_reg, hy_reg, ly_reg;
    logic [nps_pkg::DIST_BITS-1:0] tx_reg, ty_reg, dist_reg, dist_next;
    logic [63:0]           sum;

    // cell 0: absolute differences
    always_comb begin
        dxs     = DW'($signed(qx)) - DW'($signed(in_x));
        dys     = DW'($signed(qy)) - DW'($signed(in_y));
        dx_next = dxs[DW-1] ? COORD_BITS'(-dxs) : COORD_BITS'(dxs);
        dy_next = dys[DW-1] ? COORD_BITS'(-dys) : COORD_BITS'(dys);
    end

    // cell 2 operands, cell 4 sum
    always_comb begin
        sqx64 = 64'(sqx_reg);
        sqy64 = 64'(sqy_reg);
        sum   = 64'(tx_reg) + 64'(ty_reg);
        if (!mode_2d) begin
            dist_next = nps_pkg::DIST_BITS'(dx_reg[STAGES-2]);
        end else if (sum[63]) begin
            dist_next = nps_pkg::DIST_MAX;
        end else begin
            dist_next = sum[62:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            v_reg <= {v_reg[STAGES-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg[0] <= in_idx;
        x_reg[0]   <= in_x;
        y_reg[0]   <= in_y;
        for (int i = 1; i < STAGES; i++) begin
            idx_reg[i] <= idx_reg[i-1];
            x_reg[i]   <= x_reg[i-1];
            y_reg[i]   <= y_reg[i-1];
        end
        dx_reg[0] <= dx_next;
        for (int i = 1; i < STAGES - 1; i++) begin
            dx_reg[i] <= dx_reg[i-1];
        end
        dy_reg   <= dy_next;
        sqx_reg  <= SQ'(dx_reg[0]) * SQ'(dx_reg[0]);
        sqy_reg  <= SQ'(dy_reg) * SQ'(dy_reg);
        hx_reg   <= PW'(sqx64[63:32]) * PW'(x_weight);
        lx_reg   <= PW'(sqx64[31:0]) * PW'(x_weight);
        hy_reg   <= PW'(sqy64[63:32]) * PW'(y_weight);
        ly_reg   <= PW'(sqy64[31:0]) * PW'(y_weight);
        tx_reg   <= wterm(hx_reg, lx_reg);
        ty_reg   <= wterm(hy_reg, ly_reg);
        dist_reg <= dist_next;
    end

    assign out_valid = v_reg[STAGES-1];
    assign out_idx   = idx_reg[STAGES-1];
    assign out_x     = x_reg[STAGES-1];
    assign out_y     = y_reg[STAGES-1];
    assign out_dist  = dist_reg;
    assign busy      = |v_reg;

endmodule

>>> rtl/core/nps_best.sv
// nps_best: holds the best candidate seen so far during a scan
// depends on nps_pkg

module nps_best #(
    parameter int COORD_BITS = nps_pkg::COORD_BITS_DEF,
    parameter int IDX_BITS   = 10
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          clear,
    input  logic                          in_valid,
    input  logic [IDX_BITS-1:0]           in_idx,
    input  logic [COORD_BITS-1:0]         in_x,
    input  logic [COORD_BITS-1:0]         in_y,
    input  logic [nps_pkg::DIST_BITS-1:0] in_dist,
    output logic                          found,
    output logic [IDX_BITS-1:0]           best_idx,
    output logic [COORD_BITS-1:0]         best_x,
    output logic [COORD_BITS-1:0]         best_y,
    output logic [nps_pkg::DIST_BITS-1:0] best_dist
);

    logic                          found_reg;
    logic [IDX_BITS-1:0]           idx_reg;
    logic [COORD_BITS-1:0]         x_reg, y_reg;
    logic [nps_pkg::DIST_BITS-1:0] dist_reg;
    logic                          take;

    // strict compare keeps the lowest index on ties
    assign take = in_valid && (!found_reg || in_dist < dist_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            found_reg <= 1'b0;
        end else if (clear) begin
            found_reg <= 1'b0;
        end else if (take) begin
            found_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (clear) begin
            idx_reg  <= '0;
            x_reg    <= '0;
            y_reg    <= '0;
            dist_reg <= nps_pkg::DIST_MAX;
        end else if (take) begin
            idx_reg  <= in_idx;
            x_reg    <= in_x;
            y_reg    <= in_y;
            dist_reg <= in_dist;
        end
    end

    assign found     = found_reg;
    assign best_idx  = idx_reg;
    assign best_x    = x_reg;
    assign best_y    = y_reg;
    assign best_dist = dist_reg;

endmodule

>>> rtl/core/nps_ctrl.sv
// nps_ctrl: command sequencer and scan address counter
// depends on nps_pkg

module nps_ctrl #(
    parameter int MAX_POINTS = nps_pkg::MAX_POINTS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_fire,
    input  nps_pkg::cmd_t                     cmd,
    input  logic [$clog2(MAX_POINTS+1)-1:0]   count,
    input  logic                              busy,
    input  logic                              out_free,
    output nps_pkg::scan_ctrl_t               ctrl,
    output logic [$clog2(MAX_POINTS)-1:0]     rd_addr
);

    localparam int IDX_BITS   = $clog2(MAX_POINTS);
    localparam int COUNT_BITS = $clog2(MAX_POINTS + 1);

    nps_pkg::state_t         state_reg, state_next;
    logic [COUNT_BITS-1:0]   addr_reg;
    logic                    scan_end;
    logic                    is_query;

    assign scan_end = (addr_reg == count);
    assign is_query = (cmd == nps_pkg::CMD_NEAREST_X) || (cmd == nps_pkg::CMD_NEAREST_2D);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            nps_pkg::ST_IDLE: begin
                if (s_fire) begin
                    state_next = is_query ? nps_pkg::ST_SCAN : nps_pkg::ST_DONE;
                end
            end
            nps_pkg::ST_SCAN: begin
                if (scan_end) begin
                    state_next = nps_pkg::ST_DRAIN;
                end
            end
            nps_pkg::ST_DRAIN: begin
                if (!busy) begin
                    state_next = nps_pkg::ST_DONE;
                end
            end
            nps_pkg::ST_DONE: begin
                if (out_free) begin
                    state_next = nps_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = nps_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        ctrl = '0;
        case (state_reg)
            nps_pkg::ST_IDLE:  ctrl.s_ready  = 1'b1;
            nps_pkg::ST_SCAN:  ctrl.rd_en    = !scan_end;
            nps_pkg::ST_DRAIN: ctrl          = '0;
            nps_pkg::ST_DONE:  ctrl.load_out = out_free;
            default:           ctrl          = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= nps_pkg::ST_IDLE;
            addr_reg  <= '0;
        end else begin
            state_reg <= state_next;
            if (s_fire) begin
                addr_reg <= '0;
            end else if (ctrl.rd_en) begin
                addr_reg <= addr_reg + 1'b1;
            end
        end
    end

    assign rd_addr = addr_reg[IDX_BITS-1:0];

endmodule

>>> test/nearest_point_search_tb.sv
`timescale 1ns / 100ps
// nearest_point_search_tb: self-checking bench for the nearest point search block,
// predicts every result transaction and compares it field by field
// depends on nps_pkg and the nearest_point_search rtl

module nearest_point_search_tb;

    import nps_pkg::*;

    localparam int CB             = COORD_BITS_DEF;
    localparam int MAX_PTS        = MAX_POINTS_DEF;
    localparam int S_W            = ((2*CB+7)/8)*8;
    localparam int M_W            = ((INDEX_BITS + DIST_BITS + COUNT_OUT_BITS + 6*CB + 7)/8)*8;
    localparam int OFF_DIST       = INDEX_BITS;
    localparam int OFF_SX         = OFF_DIST + DIST_BITS;
    localparam int OFF_SY         = OFF_SX + CB;
    localparam int OFF_CNT        = OFF_SY + CB;
    localparam int OFF_XMIN       = OFF_CNT + COUNT_OUT_BITS;
    localparam int OFF_XMAX       = OFF_XMIN + CB;
    localparam int OFF_YMIN       = OFF_XMAX + CB;
    localparam int OFF_YMAX       = OFF_YMIN + CB;
    localparam int RANDOM_ITEMS   = 550;
    localparam int HOLD_CYCLES    = 400;
    localparam int TIMEOUT_CYCLES = 600000;

    localparam logic signed [CB-1:0] C_MAX = {1'b0, {(CB-1){1'b1}}};
    localparam logic signed [CB-1:0] C_MIN = {1'b1, {(CB-1){1'b0}}};
    localparam logic [CFG_INDEX_BITS-1:0] CFG_UNUSED_LO = 8'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_UNUSED_HI = 8'hFF;

    typedef struct {
        cmd_t                cmd;
        logic signed [CB-1:0] x;
        logic signed [CB-1:0] y;
    } search_cmd_t;

    typedef struct {
        logic                       found;
        logic [INDEX_BITS-1:0]      index;
        logic [DIST_BITS-1:0]       distance;
        logic signed [CB-1:0]       sel_x;
        logic signed [CB-1:0]       sel_y;
        logic [COUNT_OUT_BITS-1:0]  count;
        logic                       dropped;
        logic signed [CB-1:0]       x_min;
        logic signed [CB-1:0]       x_max;
        logic signed [CB-1:0]       y_min;
        logic signed [CB-1:0]       y_max;
    } search_result_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;

    logic                       s_axis_tvalid = 1'b0;
    logic                       s_axis_tready;
    logic [S_W-1:0]             s_axis_tdata = '0;
    logic [CMD_BITS-1:0]        s_axis_tuser = '0;
    logic                       m_axis_tvalid;
    logic                       m_axis_tready = 1'b0;
    logic [M_W-1:0]             m_axis_tdata;
    logic [FLAG_BITS-1:0]       m_axis_tuser;
    logic                       cfg_valid = 1'b0;
    logic                       cfg_ready;
    logic [CFG_INDEX_BITS-1:0]  cfg_index = '0;
    logic [WEIGHT_BITS-1:0]     cfg_data = '0;

    // predicted block state
    logic signed [CB-1:0] x_pts [MAX_PTS];
    logic signed [CB-1:0] y_pts [MAX_PTS];
    int                   pt_count = 0;
    logic signed [CB-1:0] lo_x, hi_x, lo_y, hi_y;
    logic [WEIGHT_BITS-1:0] x_wt = WEIGHT_RESET;
    logic [WEIGHT_BITS-1:0] y_wt = WEIGHT_RESET;

    search_cmd_t    pending_cmds [$];
    search_result_t expected_results [$];
    search_cmd_t    offer_cmd;
    bit             offer_busy = 1'b0;
    bit             no_idle = 1'b0;
    bit             hold_arm = 1'b0;
    bit             hold_taken = 1'b0;
    int unsigned    hold_left = 0;
    int unsigned    mismatches = 0;
    int unsigned    cycle_cnt = 0;
    int             queued_items = 0;
    int             fill_est = 0;

    nearest_point_search i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),  // x_coord, y_coord
        .s_axis_tuser  (s_axis_tuser),  // command
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),  // nearest_index, distance, sel_x, sel_y, stored_count,
                                        // x_min, x_max, y_min, y_max
        .m_axis_tuser  (m_axis_tuser),  // found, dropped
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    function automatic void clear_extremes();
        lo_x = C_MAX;
        lo_y = C_MAX;
        hi_x = C_MIN;
        hi_y = C_MIN;
    endfunction

    function automatic logic [CB-1:0] abs_diff(logic signed [CB-1:0] a, logic signed [CB-1:0] b);
        logic [CB:0] diff;
        diff = {a[CB-1], a} - {b[CB-1], b};
        return diff[CB] ? CB'(-diff) : diff[CB-1:0];
    endfunction

    // floor(d*d*w / 256)
    function automatic logic [79:0] weighted_sq(logic [CB-1:0] d, logic [WEIGHT_BITS-1:0] w);
        logic [79:0] p;
        p = d;
        p = (p * p * w) >> 8;
        return p;
    endfunction

    function automatic search_result_t apply_command(search_cmd_t c);
        search_result_t       r;
        logic [DIST_BITS-1:0] d;
        logic [79:0]          wsum;
        r = '{default: '0};
        case (c.cmd)
            CMD_CLEAR: begin
                pt_count = 0;
                clear_extremes();
            end
            CMD_ADD: begin
                if (pt_count >= MAX_PTS) begin
                    r.dropped = 1'b1;
                end else begin
                    x_pts[pt_count] = c.x;
                    y_pts[pt_count] = c.y;
                    pt_count++;
                    if (c.x < lo_x) lo_x = c.x;
                    if (c.x > hi_x) hi_x = c.x;
                    if (c.y < lo_y) lo_y = c.y;
                    if (c.y > hi_y) hi_y = c.y;
                end
            end
            default: begin
                r.distance = DIST_MAX;
                for (int i = 0; i < pt_count; i++) begin
                    if (c.cmd == CMD_NEAREST_X) begin
                        d = abs_diff(c.x, x_pts[i]);
                    end else begin
                        wsum = weighted_sq(abs_diff(c.x, x_pts[i]), x_wt)
                             + weighted_sq(abs_diff(c.y, y_pts[i]), y_wt);
                        d = (wsum > DIST_MAX) ? DIST_MAX : wsum[DIST_BITS-1:0];
                    end
                    if (!r.found || d < r.distance) begin
                        r.found = 1'b1;
                        r.distance = d;
                        r.index = INDEX_BITS'(i);
                        r.sel_x = x_pts[i];
                        r.sel_y = y_pts[i];
                    end
                end
            end
        endcase
        r.count = COUNT_OUT_BITS'(pt_count);
        r.x_min = lo_x;
        r.x_max = hi_x;
        r.y_min = lo_y;
        r.y_max = hi_y;
        return r;
    endfunction

    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    function automatic void compare_result(search_result_t want);
        search_result_t got;
        got.found    = m_axis_tuser[0];
        got.dropped  = m_axis_tuser[1];
        got.index    = m_axis_tdata[0 +: INDEX_BITS];
        got.distance = m_axis_tdata[OFF_DIST +: DIST_BITS];
        got.sel_x    = m_axis_tdata[OFF_SX +: CB];
        got.sel_y    = m_axis_tdata[OFF_SY +: CB];
        got.count    = m_axis_tdata[OFF_CNT +: COUNT_OUT_BITS];
        got.x_min    = m_axis_tdata[OFF_XMIN +: CB];
        got.x_max    = m_axis_tdata[OFF_XMAX +: CB];
        got.y_min    = m_axis_tdata[OFF_YMIN +: CB];
        got.y_max    = m_axis_tdata[OFF_YMAX +: CB];
        check_field("found", want.found, got.found);
        check_field("nearest_index", want.index, got.index);
        check_field("distance", want.distance, got.distance);
        check_field("sel_x", want.sel_x, got.sel_x);
        check_field("sel_y", want.sel_y, got.sel_y);
        check_field("stored_count", want.count, got.count);
        check_field("dropped", want.dropped, got.dropped);
        check_field("x_min", want.x_min, got.x_min);
        check_field("x_max", want.x_max, got.x_max);
        check_field("y_min", want.y_min, got.y_min);
        check_field("y_max", want.y_max, got.y_max);
    endfunction

    // command driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
            offer_busy = 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                expected_results.push_back(apply_command(offer_cmd));
                offer_busy = 1'b0;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pending_cmds.size() != 0 && (no_idle || $urandom_range(99, 0) >= 11)) begin
                    offer_cmd = pending_cmds.pop_front();
                    offer_busy = 1'b1;
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= S_W'({offer_cmd.y, offer_cmd.x});
                    s_axis_tuser <= offer_cmd.cmd;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result transaction, expected none, actual %0h",
                             $time, m_axis_tdata);
                    mismatches++;
                end else begin
                    compare_result(expected_results.pop_front());
                end
            end
            if (hold_arm && !hold_taken) begin
                hold_taken = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= no_idle || $urandom_range(99, 0) >= 11;
            end
        end
    end

    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt == TIMEOUT_CYCLES) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic void queue_command(cmd_t c, logic signed [CB-1:0] x,
                                          logic signed [CB-1:0] y);
        pending_cmds.push_back('{c, x, y});
        queued_items++;
        if (c == CMD_CLEAR) fill_est = 0;
        else if (c == CMD_ADD && fill_est < MAX_PTS) fill_est++;
    endfunction

    function automatic logic signed [CB-1:0] rand_coord();
        logic signed [CB-1:0] v;
        case ($urandom_range(7, 0))
            0, 1, 2: v = CB'($urandom);
            3:       v = $urandom_range(1, 0) ? C_MAX : C_MIN;
            4:       v = $urandom_range(1, 0) ? '0 : '1;
            default: begin
                v = CB'($urandom_range(512, 0));
                v = v - 256;
            end
        endcase
        return v;
    endfunction

    function automatic logic [WEIGHT_BITS-1:0] rand_weight();
        case ($urandom_range(3, 0))
            0:       return '0;
            1:       return '1;
            default: return WEIGHT_BITS'($urandom);
        endcase
    endfunction

    task automatic wait_drained();
        while (pending_cmds.size() != 0 || offer_busy || expected_results.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [WEIGHT_BITS-1:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        if (idx == CFG_X_WEIGHT) x_wt = val;
        else if (idx == CFG_Y_WEIGHT) y_wt = val;
        cfg_valid <= 1'b0;
    endtask

    // usually an optional clear, a burst of adds with some repeated points, then queries, some at the last added point
    task automatic random_segment();
        int                   n_add;
        logic signed [CB-1:0] lx, ly, qx, qy;
        if ($urandom_range(7, 0) == 0) begin
            repeat ($urandom_range(6, 1))
                queue_command(cmd_t'($urandom_range(3, 0)), rand_coord(), rand_coord());
            return;
        end
        if (fill_est > 40 || $urandom_range(3, 0) != 0)
            queue_command(CMD_CLEAR, rand_coord(), rand_coord());
        n_add = $urandom_range(12, 1);
        lx = rand_coord();
        ly = rand_coord();
        repeat (n_add) begin
            if ($urandom_range(4, 0) != 0) begin
                lx = rand_coord();
                ly = rand_coord();
            end
            queue_command(CMD_ADD, lx, ly);
        end
        repeat ($urandom_range(6, 2)) begin
            qx = ($urandom_range(2, 0) == 0) ? lx : rand_coord();
            qy = ($urandom_range(2, 0) == 0) ? ly : rand_coord();
            queue_command($urandom_range(1, 0) ? CMD_NEAREST_X : CMD_NEAREST_2D, qx, qy);
        end
    endtask

    initial begin
        int                   seg;
        int                   base;
        logic signed [CB-1:0] px, py;
        clear_extremes();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // directed, reset weights
        queue_command(CMD_NEAREST_X, '0, '0);
        queue_command(CMD_NEAREST_2D, C_MAX, C_MIN);
        queue_command(CMD_ADD, C_MAX, C_MAX);
        queue_command(CMD_ADD, C_MIN, C_MIN);
        queue_command(CMD_ADD, '0, '0);
        queue_command(CMD_ADD, C_MIN, C_MAX);
        queue_command(CMD_ADD, C_MAX, C_MIN);
        queue_command(CMD_NEAREST_X, C_MIN, 24'sd5);
        queue_command(CMD_NEAREST_X, C_MAX, '0);
        queue_command(CMD_NEAREST_2D, C_MIN, C_MIN);
        queue_command(CMD_NEAREST_2D, C_MAX, C_MAX);
        queue_command(CMD_ADD, '0, '0);
        queue_command(CMD_NEAREST_2D, '0, '0);
        queue_command(CMD_NEAREST_X, '0, C_MAX);
        queue_command(CMD_NEAREST_X, 24'sd1, C_MIN);
        queue_command(CMD_CLEAR, C_MAX, C_MIN);
        queue_command(CMD_NEAREST_X, '0, '0);
        queue_command(CMD_NEAREST_2D, '0, '0);
        queue_command(CMD_ADD, '1, '1);
        queue_command(CMD_NEAREST_2D, '0, '0);
        queue_command(CMD_NEAREST_X, 24'sd12345, '0);
        queue_command(CMD_CLEAR, '0, '0);
        wait_drained();

        write_reg(CFG_X_WEIGHT, '0);
        write_reg(CFG_Y_WEIGHT, '1);
        write_reg(CFG_UNUSED_LO, 16'h1234);
        write_reg(CFG_UNUSED_HI, '1);

        // fill the store, overflow it and search the full store
        px = '0;
        py = '0;
        for (int n = 0; n < MAX_PTS; n++) begin
            px = rand_coord();
            py = rand_coord();
            queue_command(CMD_ADD, px, py);
        end
        queue_command(CMD_ADD, C_MAX, C_MAX);
        queue_command(CMD_NEAREST_X, px, rand_coord());
        queue_command(CMD_NEAREST_2D, px, py);
        queue_command(CMD_NEAREST_X, rand_coord(), rand_coord());
        queue_command(CMD_NEAREST_2D, rand_coord(), rand_coord());
        queue_command(CMD_ADD, C_MIN, C_MIN);
        queue_command(CMD_NEAREST_2D, C_MIN, C_MAX);
        queue_command(CMD_CLEAR, '0, '0);
        wait_drained();

        write_reg(CFG_X_WEIGHT, '1);
        write_reg(CFG_Y_WEIGHT, '0);

        seg = 0;
        base = queued_items;
        while (queued_items - base < RANDOM_ITEMS) begin
            if (seg % 8 == 7) begin
                wait_drained();
                write_reg(CFG_X_WEIGHT, rand_weight());
                write_reg(CFG_Y_WEIGHT, rand_weight());
            end
            if (seg == 10) hold_arm = 1'b1;
            if (seg == 20) no_idle = 1'b1;
            if (seg == 30) begin
                wait_drained();
                no_idle = 1'b0;
            end
            random_segment();
            seg++;
        end

        wait_drained();
        repeat (30) @(posedge aclk);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
